FILE: design/pvp_pkg.sv
`default_nettype none

package pvp_pkg;

   // normalized operands are kept below 2^NORM_BITS
   localparam int NORM_BITS   = 24;
   localparam int DIFF_BITS   = 33;
   localparam int SHIFT_BITS  = DIFF_BITS - NORM_BITS;
   localparam int SQ_BITS     = 2 * NORM_BITS;

   localparam int INT_STEPS   = 5;
   localparam int FRAC_STEPS  = 31;
   localparam int DIV_STAGES  = INT_STEPS + FRAC_STEPS;

   localparam int SERIES_TERMS = 20;

   localparam logic [30:0] LN2_Q31 = 31'h58B9_0BFC;
   localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
   localparam logic [15:0] MIX_ONE = 16'd32768;

   typedef enum logic [2:0] {
      CSR_AMPLITUDE = 3'd0,
      CSR_CENTER    = 3'd1,
      CSR_FWHM      = 3'd2,
      CSR_GAUSS     = 3'd3
   } csr_index_type;

   // values that ride along with the gaussian path
   typedef struct packed {
      logic [31:0]          lor;
      logic [INT_STEPS-1:0] k;
      logic                 g_zero;
   } side_type;

endpackage

`default_nettype wire

FILE: design/pvp_divider.sv
`default_nettype none

module pvp_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic                         in_valid,
   input  wire logic [pvp_pkg::SQ_BITS-1:0]  in_f2,
   input  wire logic [pvp_pkg::SQ_BITS-1:0]  in_a2,
   input  wire logic                         in_fzero,
   output logic                              out_valid,
   output logic [30:0]                       out_r,
   output pvp_pkg::side_type                 out_side
);

   localparam int GW = pvp_pkg::SQ_BITS + 6;
   localparam int LW = pvp_pkg::SQ_BITS + 2;

   typedef struct packed {
      logic [GW-1:0]                    grem;
      logic [pvp_pkg::SQ_BITS-1:0]      f2;
      logic [30:0]                      gq;
      logic [LW-1:0]                    lrem;
      logic [LW-2:0]                    lb;
      logic [30:0]                      lq;
      logic [pvp_pkg::INT_STEPS-1:0]    k;
      logic                             lor_one;
      logic                             fzero;
      logic                             big;
   } div_type;

   div_type                       st_ff [0:pvp_pkg::DIV_STAGES];
   logic [pvp_pkg::DIV_STAGES:0]  v_ff;
   div_type                       st0_in;

   always_comb begin
      st0_in         = '0;
      st0_in.grem    = GW'({in_a2, 2'b00});
      st0_in.f2      = in_f2;
      st0_in.lrem    = LW'(in_f2);
      st0_in.lb      = (LW-1)'(in_f2) + (LW-1)'(in_a2);
      st0_in.lor_one = (in_a2 == '0);
      st0_in.fzero   = in_fzero;
      // quotient 4*a2/f2 of 32 or more leaves no gaussian term
      st0_in.big     = GW'({in_a2, 2'b00}) >= GW'({in_f2, 5'b00000});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= st0_in;
      end
   end

   for (genvar i = 0; i < pvp_pkg::DIV_STAGES; i++) begin : g_step
      localparam int SH = (i < pvp_pkg::INT_STEPS) ? pvp_pkg::INT_STEPS - 1 - i : 0;
      div_type       step_in;
      logic [GW-1:0] cmp;
      logic [GW-1:0] gsh;
      logic [LW-1:0] lsh;

      always_comb begin
         step_in = st_ff[i];
         cmp     = GW'(st_ff[i].f2) << SH;
         gsh     = {st_ff[i].grem[GW-2:0], 1'b0};
         lsh     = {st_ff[i].lrem[LW-2:0], 1'b0};
         if (i < pvp_pkg::INT_STEPS) begin
            if (st_ff[i].grem >= cmp) begin
               step_in.grem  = st_ff[i].grem - cmp;
               step_in.k[SH] = 1'b1;
            end
         end else begin
            if (gsh >= GW'(st_ff[i].f2)) begin
               step_in.grem = gsh - GW'(st_ff[i].f2);
               step_in.gq   = {st_ff[i].gq[29:0], 1'b1};
            end else begin
               step_in.grem = gsh;
               step_in.gq   = {st_ff[i].gq[29:0], 1'b0};
            end
         end
         if (i < pvp_pkg::FRAC_STEPS) begin
            if (lsh >= LW'(st_ff[i].lb)) begin
               step_in.lrem = lsh - LW'(st_ff[i].lb);
               step_in.lq   = {st_ff[i].lq[29:0], 1'b1};
            end else begin
               step_in.lrem = lsh;
               step_in.lq   = {st_ff[i].lq[29:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[i+1] <= step_in;
         end
      end
   end

   always_comb begin
      out_valid       = v_ff[pvp_pkg::DIV_STAGES];
      out_r           = st_ff[pvp_pkg::DIV_STAGES].gq;
      out_side.k      = st_ff[pvp_pkg::DIV_STAGES].k;
      out_side.g_zero = st_ff[pvp_pkg::DIV_STAGES].fzero | st_ff[pvp_pkg::DIV_STAGES].big;
      if (st_ff[pvp_pkg::DIV_STAGES].fzero) begin
         out_side.lor = '0;
      end else if (st_ff[pvp_pkg::DIV_STAGES].lor_one) begin
         out_side.lor = pvp_pkg::ONE_Q31;
      end else begin
         out_side.lor = {1'b0, st_ff[pvp_pkg::DIV_STAGES].lq};
      end
   end

endmodule

`default_nettype wire

FILE: design/pvp_series.sv
`default_nettype none

module pvp_series (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire logic [30:0]       in_y,
   input  pvp_pkg::side_type      in_side,
   output logic                   out_valid,
   output logic signed [33:0]     out_sum,
   output pvp_pkg::side_type      out_side
);

   localparam int NT = pvp_pkg::SERIES_TERMS;

   typedef struct packed {
      logic [31:0]         term;
      logic [30:0]         y;
      logic signed [33:0]  sum;
      pvp_pkg::side_type   side;
   } acc_type;

   acc_type       acc_ff  [0:NT];
   acc_type       pa_ff   [0:NT-1];
   acc_type       pb_ff   [0:NT-1];
   logic [61:0]   prod_ff [0:NT-1];
   logic [30:0]   p_ff    [0:NT-1];
   logic [63:0]   mq_ff   [0:NT-1];
   logic [NT:0]   acc_v_ff;
   logic [NT-1:0] pa_v_ff;
   logic [NT-1:0] pb_v_ff;
   acc_type       acc0_in;

   always_comb begin
      acc0_in.term = pvp_pkg::ONE_Q31;
      acc0_in.y    = in_y;
      acc0_in.sum  = $signed(34'(pvp_pkg::ONE_Q31));
      acc0_in.side = in_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_v_ff[0] <= 1'b0;
      end else if (adv) begin
         acc_v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_ff[0] <= acc0_in;
      end
   end

   for (genvar i = 0; i < NT; i++) begin : g_term
      localparam int          N     = i + 1;
      localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);
      logic [61:0]        prod_in;
      logic [30:0]        p_in;
      logic [63:0]        mq_in;
      logic [30:0]        q0;
      logic [35:0]        rem;
      logic [30:0]        q;
      acc_type            acc_in;

      // term * y in q0.31
      assign prod_in = 62'(acc_ff[i].term) * 62'(acc_ff[i].y);

      // divide by n through its reciprocal, then one correction step
      assign p_in  = prod_ff[i][61:31];
      assign mq_in = 64'(p_in) * 64'(RECIP);

      always_comb begin
         q0     = mq_ff[i][62:32];
         rem    = 36'(p_ff[i]) - 36'(q0) * 36'(N);
         q      = (rem >= 36'(N)) ? q0 + 31'd1 : q0;
         acc_in = pb_ff[i];
         acc_in.term = {1'b0, q};
         if ((N % 2) == 1) begin
            acc_in.sum = pb_ff[i].sum - $signed({3'b000, q});
         end else begin
            acc_in.sum = pb_ff[i].sum + $signed({3'b000, q});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pa_v_ff[i]    <= 1'b0;
            pb_v_ff[i]    <= 1'b0;
            acc_v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            pa_v_ff[i]    <= acc_v_ff[i];
            pb_v_ff[i]    <= pa_v_ff[i];
            acc_v_ff[i+1] <= pb_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            pa_ff[i]    <= acc_ff[i];
            prod_ff[i]  <= prod_in;
            pb_ff[i]    <= pa_ff[i];
            p_ff[i]     <= p_in;
            mq_ff[i]    <= mq_in;
            acc_ff[i+1] <= acc_in;
         end
      end
   end

   assign out_valid = acc_v_ff[NT];
   assign out_sum   = acc_ff[NT].sum;
   assign out_side  = acc_ff[NT].side;

endmodule

`default_nettype wire

FILE: design/pseudo_voigt_profile.sv
// throughput: one transaction per cycle while no response is stalled, set by a
// fully pipelined datapath (36 divider stages, 3 stages per series term)
// a stalled response holds the whole pipeline; nothing is dropped
// reset clears all valid bits and loads the register defaults
`default_nettype none

module pseudo_voigt_profile (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_sample_position,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_profile_value,
   output logic                    rsp_width_error,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   localparam int NB = pvp_pkg::NORM_BITS;
   localparam int DB = pvp_pkg::DIFF_BITS;

   logic signed [31:0] amp_ff;
   logic signed [31:0] center_ff;
   logic [30:0]        fwhm_ff;
   logic [15:0]        gauss_ff;

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff, vg_ff, vm_ff, vs_ff, va_ff, rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff    <= 32'sd65536;
         center_ff <= '0;
         fwhm_ff   <= 31'd65536;
         gauss_ff  <= 16'd16384;
      end else if (csr_valid) begin
         unique case (pvp_pkg::csr_index_type'(csr_index))
            pvp_pkg::CSR_AMPLITUDE: amp_ff    <= csr_data;
            pvp_pkg::CSR_CENTER:    center_ff <= csr_data;
            pvp_pkg::CSR_FWHM:      fwhm_ff   <= csr_data[30:0];
            pvp_pkg::CSR_GAUSS:     gauss_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // valid chain of the top-level stages
   logic div_valid, ser_valid;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         vg_ff <= 1'b0; vm_ff <= 1'b0; vs_ff <= 1'b0; va_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vg_ff <= ser_valid;
         vm_ff <= vg_ff;
         vs_ff <= vm_ff;
         va_ff <= vs_ff;
         rsp_valid_ff <= va_ff;
      end
   end

   // distance from the center
   logic signed [DB-1:0] d1;
   logic [DB-1:0]        a1_in, a1_ff;
   assign d1    = DB'(req_sample_position) - DB'(center_ff);
   assign a1_in = d1[DB-1] ? DB'(-d1) : DB'(d1);

   // larger of distance and width
   logic [DB-1:0] m2_in, m2_ff, a2_ff;
   assign m2_in = (a1_ff > DB'(fwhm_ff)) ? a1_ff : DB'(fwhm_ff);

   // shift both into NB bits
   logic [pvp_pkg::SHIFT_BITS-1:0] hi3;
   logic [3:0]                     sh3;
   logic [NB-1:0]                  an3_in, fn3_in, an3_ff, fn3_ff;
   logic [DB-1:0]                  ash3, fsh3;
   always_comb begin
      hi3 = m2_ff[DB-1:NB];
      sh3 = '0;
      for (int j = 0; j < pvp_pkg::SHIFT_BITS; j++) begin
         if (hi3[j]) sh3 = 4'(j + 1);
      end
      ash3   = a2_ff >> sh3;
      fsh3   = DB'(fwhm_ff) >> sh3;
      an3_in = ash3[NB-1:0];
      fn3_in = fsh3[NB-1:0];
   end

   // squares
   logic [pvp_pkg::SQ_BITS-1:0] asq_in, fsq_in, asq_ff, fsq_ff;
   logic                        fz4_ff;
   assign asq_in = pvp_pkg::SQ_BITS'(an3_ff) * pvp_pkg::SQ_BITS'(an3_ff);
   assign fsq_in = pvp_pkg::SQ_BITS'(fn3_ff) * pvp_pkg::SQ_BITS'(fn3_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff  <= a1_in;
         m2_ff  <= m2_in;
         a2_ff  <= a1_ff;
         an3_ff <= an3_in;
         fn3_ff <= fn3_in;
         asq_ff <= asq_in;
         fsq_ff <= fsq_in;
         fz4_ff <= (fn3_ff == '0);
      end
   end

   logic [30:0]       div_r;
   pvp_pkg::side_type div_side;

   pvp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_f2     (fsq_ff),
      .in_a2     (asq_ff),
      .in_fzero  (fz4_ff),
      .out_valid (div_valid),
      .out_r     (div_r),
      .out_side  (div_side)
   );

   // fraction of t times ln2
   logic [61:0] yprod;
   logic [30:0] y_in;
   assign yprod = 62'(div_r) * 62'(pvp_pkg::LN2_Q31);
   assign y_in  = yprod[61:31];

   logic signed [33:0] ser_sum;
   pvp_pkg::side_type  ser_side;

   pvp_series u_series (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_y      (y_in),
      .in_side   (div_side),
      .out_valid (ser_valid),
      .out_sum   (ser_sum),
      .out_side  (ser_side)
   );

   // clamp the series and apply the integer power of two
   logic [31:0] gsum, gau_in, gau_ff, lor_ff;
   always_comb begin
      if (ser_sum < 0) begin
         gsum = '0;
      end else if (ser_sum > $signed(34'(pvp_pkg::ONE_Q31))) begin
         gsum = pvp_pkg::ONE_Q31;
      end else begin
         gsum = ser_sum[31:0];
      end
      gau_in = ser_side.g_zero ? '0 : (gsum >> ser_side.k);
   end

   // weighted shape terms
   logic [15:0] mix;
   logic [47:0] pg_in, pl_in, pg_ff, pl_ff;
   assign mix   = (gauss_ff > pvp_pkg::MIX_ONE) ? pvp_pkg::MIX_ONE : gauss_ff;
   assign pg_in = 48'(mix) * 48'(gau_ff);
   assign pl_in = 48'(pvp_pkg::MIX_ONE - mix) * 48'(lor_ff);

   logic [48:0] shsum;
   logic [31:0] shape_in, shape_ff;
   assign shsum    = 49'(pg_ff) + 49'(pl_ff) + 49'(1 << 14);
   assign shape_in = shsum[46:15];

   logic [31:0] amag;
   logic [63:0] aprod_in, aprod_ff;
   assign amag     = amp_ff[31] ? 32'(-amp_ff) : 32'(amp_ff);
   assign aprod_in = 64'(amag) * 64'(shape_ff);

   // rounding, sign and saturation
   logic [64:0]        rnd;
   logic [33:0]        mag;
   logic signed [31:0] val_in;
   assign rnd = 65'(aprod_ff) + 65'(64'd1 << 30);
   assign mag = rnd[64:31];
   always_comb begin
      if (fwhm_ff == '0) begin
         val_in = '0;
      end else if (amp_ff[31]) begin
         val_in = 32'(-mag);
      end else if (mag > 34'h0_7FFF_FFFF) begin
         val_in = 32'sh7FFF_FFFF;
      end else begin
         val_in = mag[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gau_ff            <= gau_in;
         lor_ff            <= ser_side.lor;
         pg_ff             <= pg_in;
         pl_ff             <= pl_in;
         shape_ff          <= shape_in;
         aprod_ff          <= aprod_in;
         rsp_profile_value <= val_in;
         rsp_width_error   <= (fwhm_ff == '0);
      end
   end

endmodule

`default_nettype wire

FILE: design/pvp_checker.sv
`default_nettype none

module pvp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_profile_value,
   input wire logic        rsp_width_error
);

   // a zero width forces a zero value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_width_error |-> rsp_profile_value == 32'd0)
      else $error("width error with nonzero value");

   // the pipeline only stalls behind a waiting response
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_ready_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response accepted");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_profile_value))
      else $error("stalled response changed");

endmodule

bind pseudo_voigt_profile pvp_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_profile_value (rsp_profile_value),
   .rsp_width_error   (rsp_width_error)
);

`default_nettype wire

FILE: test/pseudo_voigt_profile_test.sv
`timescale 1ns / 100ps
`default_nettype none

class profile_scoreboard;
   logic signed [31:0] amplitude;
   logic signed [31:0] center;
   logic [30:0]        fwhm;
   logic [15:0]        gauss;
   logic signed [31:0] pending_value[$];
   logic               pending_flag[$];
   int                 errors;
   int                 checked;
   int                 flagged;

   function new();
      amplitude = 32'sd65536;
      center    = 0;
      fwhm      = 31'd65536;
      gauss     = 16'd16384;
      errors    = 0;
      checked   = 0;
      flagged   = 0;
   endfunction

   function void write_reg(pvp_pkg::csr_index_type idx, logic [31:0] data);
      case (idx)
         pvp_pkg::CSR_AMPLITUDE: amplitude = data;
         pvp_pkg::CSR_CENTER:    center = data;
         pvp_pkg::CSR_FWHM:      fwhm = data[30:0];
         pvp_pkg::CSR_GAUSS:     gauss = data[15:0];
         default: ;
      endcase
   endfunction

   // floor(r * 2^31 / b) for r < b
   function logic [63:0] ratio_q31(logic [63:0] r, logic [63:0] b);
      logic [63:0] q;
      q = 0;
      for (int i = 0; i < 31; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= b) begin
            r = r - b;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function logic [63:0] decay_q31(logic [63:0] y);
      longint      sum;
      logic [63:0] term;
      sum  = 64'h8000_0000;
      term = 64'h8000_0000;
      for (int n = 1; n <= pvp_pkg::SERIES_TERMS; n++) begin
         term = ((term * y) >> 31) / n;
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sh8000_0000) sum = 64'sh8000_0000;
      return sum;
   endfunction

   function void note_sample(logic signed [31:0] x);
      longint      d, res;
      logic [63:0] a, f, m, lor, gau, mix, shape, amag, mag, f2, a2, num, k, rem, y;
      int          s;
      if (fwhm == 0) begin
         pending_value.push_back(0);
         pending_flag.push_back(1'b1);
         return;
      end
      d = longint'(x) - longint'(center);
      a = (d < 0) ? -d : d;
      f = fwhm;
      m = (a > f) ? a : f;
      s = 0;
      while ((m >> s) >= (64'd1 << 24)) s++;
      a = a >> s;
      f = f >> s;
      if (f == 0) begin
         lor = 0;
         gau = 0;
      end else begin
         f2  = f * f;
         a2  = a * a;
         num = 4 * a2;
         k   = num / f2;
         rem = num % f2;
         lor = (a2 == 0) ? 64'h8000_0000 : ratio_q31(f2, f2 + a2);
         if (k >= 32) gau = 0;
         else begin
            y   = (ratio_q31(rem, f2) * 64'h58B9_0BFC) >> 31;
            gau = decay_q31(y) >> k;
         end
      end
      mix   = (gauss > 16'd32768) ? 32768 : gauss;
      shape = (mix * gau + (32768 - mix) * lor + (64'd1 << 14)) >> 15;
      amag  = (amplitude < 0) ? -longint'(amplitude) : longint'(amplitude);
      mag   = (amag * shape + (64'd1 << 30)) >> 31;
      res   = (amplitude < 0) ? -longint'(mag) : longint'(mag);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      pending_value.push_back(res[31:0]);
      pending_flag.push_back(1'b0);
   endfunction

   function void check_result(logic signed [31:0] value, logic flag);
      logic signed [31:0] ev;
      logic               ef;
      if (pending_value.size() == 0) begin
         $error("unexpected transaction: profile_value %0d", value);
         errors++;
         return;
      end
      ev = pending_value.pop_front();
      ef = pending_flag.pop_front();
      checked++;
      if (ef) flagged++;
      if (value !== ev) begin
         $error("profile_value: expected %0d, got %0d", ev, value);
         errors++;
      end
      if (flag !== ef) begin
         $error("width_error: expected %0b, got %0b", ef, flag);
         errors++;
      end
   endfunction
endclass

module pseudo_voigt_profile_test;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 150;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic signed [31:0] req_sample_position = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [31:0] rsp_profile_value;
   logic               rsp_width_error;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [2:0]         csr_index = 0;
   logic [31:0]        csr_data = 0;

   profile_scoreboard board = new();
   int  idle_cycles = 0;
   int  samples_sent = 0;
   int  writes_done = 0;
   bit  sink_hold = 0;

   pseudo_voigt_profile uut (.*);

   always #2 clock = ~clock;

   function int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_sample(req_sample_position);
         if (rsp_valid && rsp_ready) board.check_result(rsp_profile_value, rsp_width_error);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // response stall pattern
   initial begin
      int g;
      @(negedge clock);
      forever begin
         if (sink_hold) rsp_ready <= 1'b1;
         else begin
            g = gap_length();
            if (g > 0) begin
               rsp_ready <= 1'b0;
               repeat (g) @(negedge clock);
            end
            rsp_ready <= 1'b1;
         end
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
   end

   // valid stays high into the next transaction when there is no gap
   task automatic send_sample(logic signed [31:0] x);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_position <= x;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      samples_sent++;
   endtask

   task automatic write_reg(pvp_pkg::csr_index_type idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
      writes_done++;
   endtask

   task automatic settle();
      int n;
      n = 0;
      req_valid <= 1'b0;
      while (board.pending_value.size() != 0 && n < 200000) begin
         @(negedge clock);
         n++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function logic signed [31:0] near_center(int spread);
      return board.center + $signed($urandom_range(0, 2 * spread)) - spread;
   endfunction

   task automatic random_setup();
      int p;
      p = $urandom_range(0, 9);
      write_reg(pvp_pkg::CSR_AMPLITUDE,
                (p < 2) ? {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF} : $urandom);
      write_reg(pvp_pkg::CSR_CENTER, $urandom);
      p = $urandom_range(0, 9);
      write_reg(pvp_pkg::CSR_FWHM, (p == 0) ? 32'd0 : (p < 3) ? {1'b0, 31'h7FFF_FFFF} :
                (p < 5) ? $urandom_range(1, 64) : 32'($urandom >> $urandom_range(0, 20)));
      p = $urandom_range(0, 9);
      write_reg(pvp_pkg::CSR_GAUSS, (p < 2) ? 32'd0 : (p < 4) ? 32'd32768 :
                (p == 4) ? {16'h0, 16'($urandom)} : $urandom_range(0, 32768));
   endtask

   initial begin
      logic [30:0] w;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults first, then extremes
      send_sample(0);
      send_sample(32'sh0001_0000);
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh8000_0000);
      settle();
      write_reg(pvp_pkg::CSR_AMPLITUDE, 32'h7FFF_FFFF);
      write_reg(pvp_pkg::CSR_CENTER, 32'h8000_0000);
      write_reg(pvp_pkg::CSR_FWHM, 32'h7FFF_FFFF);
      write_reg(pvp_pkg::CSR_GAUSS, 32'hFFFF);
      send_sample(32'sh8000_0000);
      send_sample(32'sh7FFF_FFFF);
      send_sample(0);
      settle();
      write_reg(pvp_pkg::CSR_AMPLITUDE, 32'h8000_0000);
      write_reg(pvp_pkg::CSR_CENTER, 32'h7FFF_FFFF);
      write_reg(pvp_pkg::CSR_FWHM, 32'd1);
      write_reg(pvp_pkg::CSR_GAUSS, 32'd0);
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh7FFF_FFFE);
      send_sample(32'sh8000_0000);
      settle();
      // width vanishes after scaling
      write_reg(pvp_pkg::CSR_GAUSS, 32'd32768);
      send_sample(32'sh8000_0000);
      send_sample(32'sh7FFF_FFFD);
      settle();
      write_reg(pvp_pkg::CSR_FWHM, 32'd0);
      send_sample(32'sh1234_5678);
      send_sample(32'sh8000_0000);
      settle();

      while (samples_sent < 820) begin
         random_setup();
         w = board.fwhm;
         repeat ($urandom_range(20, 60)) begin
            if ($urandom_range(0, 9) < 7 && w != 0)
               send_sample(near_center((w > 31'h1FFF_FFFF) ? 32'h3FFF_FFFF : 4 * w + 1));
            else
               send_sample($urandom);
         end
         if ($urandom_range(0, 3) == 0) sink_hold = 1;
         settle();
         sink_hold = 0;
      end
      settle();

      $display("covered %0d samples over %0d register writes, %0d results checked",
               samples_sent, writes_done, board.checked);
      $display("%0d results came with the zero-width flag", board.flagged);
      if (board.errors == 0 && board.pending_value.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

`default_nettype wire
